// ===== hdl/sis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg
// Shared constants and types for the sorted integer set: capacity, widths,
// operation codes, sequencer states and the control structs between modules.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_INSERT,
        ST_SHIFT_DN
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } ram_req_t;

    typedef struct packed {
        logic done;
        logic success;
        logic full;
    } res_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage
`default_nettype wire

// ===== hdl/sis_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== hdl/sis_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_cmp
// Shared key comparator: signed less-than and equality of a stored entry
// against the key under search.
// ----------------------------------------------------------------------------
module sis_cmp (
    input  wire logic        [sis_pkg::KEY_W-1:0] entry,
    input  wire logic signed [sis_pkg::KEY_W-1:0] key,
    output sis_pkg::cmp_t                         cmp
);
    import sis_pkg::*;

    always_comb begin
        cmp.lt = $signed(entry) < key;
        cmp.eq = entry == key;
    end

endmodule
`default_nettype wire

// ===== hdl/sis_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer of the sorted set: walks the key store upward one entry a cycle
// through the shared comparator, then shifts entries up or down one a cycle
// to open or close the slot.
// ----------------------------------------------------------------------------
module sis_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_accept,
    input  wire logic        [sis_pkg::FUNC_W-1:0]  in_func,
    input  wire logic signed [sis_pkg::KEY_W-1:0]   in_key,
    input  wire logic        [sis_pkg::KEY_W-1:0]   rd_data,
    output sis_pkg::ram_req_t                       ram_req,
    output sis_pkg::res_t                           result,
    output sis_pkg::status_t                        status
);
    import sis_pkg::*;

    state_t                    state_reg, state_next;
    logic [FUNC_W-1:0]         func_reg;
    logic signed [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      hit_reg, hit_next;
    logic [CNT_W-1:0]          count_last;
    logic                      in_range;
    cmp_t                      cmp;

    sis_cmp u_cmp (
        .entry (rd_data),
        .key   (key_reg),
        .cmp   (cmp)
    );

    assign count_last = count_reg - CNT_W'(1);
    assign in_range   = idx_reg < count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!in_range || !cmp.lt) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                case (func_reg)
                    FUNC_ADD: begin
                        if (!hit_reg && count_reg != CNT_W'(CAPACITY)
                                && idx_reg != count_reg) begin
                            state_next = ST_SHIFT_UP;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (hit_reg && idx_reg != count_last) begin
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SHIFT_UP: begin
                if (j_reg == idx_reg) begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                state_next = ST_IDLE;
            end
            ST_SHIFT_DN: begin
                if (j_reg == count_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        ram_req.rd_addr = '0;
        ram_req.we      = 1'b0;
        ram_req.wr_addr = '0;
        ram_req.wr_data = rd_data;
        result          = '0;
        idx_next        = idx_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // entry 0 is fetched at the accept edge
                idx_next = '0;
                hit_next = 1'b0;
            end
            ST_SEARCH: begin
                ram_req.rd_addr = ADDR_W'(idx_reg + CNT_W'(1));
                hit_next        = in_range && cmp.eq;
                if (in_range && cmp.lt) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                case (func_reg)
                    FUNC_ADD: begin
                        if (hit_reg) begin
                            result.done = 1'b1;
                        end else if (count_reg == CNT_W'(CAPACITY)) begin
                            result.done = 1'b1;
                            result.full = 1'b1;
                        end else if (idx_reg == count_reg) begin
                            // new largest key goes straight to the end
                            ram_req.we      = 1'b1;
                            ram_req.wr_addr = ADDR_W'(idx_reg);
                            ram_req.wr_data = key_reg;
                            count_next      = count_reg + CNT_W'(1);
                            result.done     = 1'b1;
                            result.success  = 1'b1;
                        end else begin
                            j_next          = count_last;
                            ram_req.rd_addr = ADDR_W'(count_last);
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!hit_reg) begin
                            result.done = 1'b1;
                        end else if (idx_reg == count_last) begin
                            count_next     = count_last;
                            result.done    = 1'b1;
                            result.success = 1'b1;
                        end else begin
                            j_next          = idx_reg + CNT_W'(1);
                            ram_req.rd_addr = ADDR_W'(idx_reg + CNT_W'(1));
                        end
                    end
                    FUNC_CONTAINS: begin
                        result.done    = 1'b1;
                        result.success = hit_reg;
                    end
                    default: begin
                        result.done = 1'b1;
                    end
                endcase
            end
            ST_SHIFT_UP: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = ADDR_W'(j_reg + CNT_W'(1));
                ram_req.rd_addr = ADDR_W'(j_reg - CNT_W'(1));
                j_next          = j_reg - CNT_W'(1);
            end
            ST_INSERT: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = ADDR_W'(idx_reg);
                ram_req.wr_data = key_reg;
                count_next      = count_reg + CNT_W'(1);
                result.done     = 1'b1;
                result.success  = 1'b1;
            end
            ST_SHIFT_DN: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = ADDR_W'(j_reg - CNT_W'(1));
                ram_req.rd_addr = ADDR_W'(j_reg + CNT_W'(1));
                j_next          = j_reg + CNT_W'(1);
                if (j_reg == count_last) begin
                    count_next     = count_last;
                    result.done    = 1'b1;
                    result.success = 1'b1;
                end
            end
            default: begin
                result.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            func_reg <= in_func;
            key_reg  <= in_key;
        end
        idx_reg <= idx_next;
        j_reg   <= j_next;
        hit_reg <= hit_next;
    end

    assign status.idle  = state_reg == ST_IDLE;
    assign status.count = count_reg;

endmodule
`default_nettype wire

// ===== hdl/sorted_integer_set.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_integer_set
// Set of distinct signed keys kept in ascending order in a key store RAM.
// A lookup walks the stored keys upward one entry per cycle until the first
// key not below the search key; add and remove then shift the entries above
// that slot. One word at a time: the next word is not taken before the result
// of the last one has been handed over on the output stream.
// Reset clears the entry count and the sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
module sorted_integer_set (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // func[1:0], key[33:2], zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // success[0], store_full[1], zero fill
);
    import sis_pkg::*;

    ram_req_t          ram_req;
    res_t              result;
    status_t           status;
    logic [KEY_W-1:0]  rd_data;
    logic              in_accept;
    logic              out_free;
    logic              m_valid_reg, m_valid_next;
    logic              success_reg;
    logic              full_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = status.idle && out_free;
    assign in_accept = s_tvalid && s_tready;

    sis_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_func   (s_tdata[FUNC_W-1:0]),
        .in_key    ($signed(s_tdata[FUNC_W+KEY_W-1:FUNC_W])),
        .rd_data   (rd_data),
        .ram_req   (ram_req),
        .result    (result),
        .status    (status)
    );

    sis_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_req.we),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (result.done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.done) begin
            success_reg <= result.success;
            full_reg    <= result.full;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, full_reg, success_reg};

    // a finished word never lands on one still waiting
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        result.done |-> out_free)
        else $error("result overwrote a pending word");

    // the sequencer is busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("ready right after accept");

    // the store never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a refused add never reports success
    a_full_no_success: assert property (@(posedge aclk) disable iff (!aresetn)
        result.done && result.full |-> !result.success)
        else $error("full and success together");

endmodule
`default_nettype wire

// ===== tb/tb_sorted_integer_set.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_integer_set
// Self-checking bench for the sorted integer set. Add, remove, contains and
// unused-code words go in through the input stream with random gaps, and a
// shadow copy of the sorted set predicts success and store_full for each one.
// The store is filled to capacity and drained again, and one long output
// stall backs the block up against its input.
// ----------------------------------------------------------------------------
import sis_pkg::*;

typedef struct packed {
    logic store_full;
    logic success;
} reply_t;

class set_tracker;
    logic [KEY_W-1:0] members[$];   // ascending, signed order
    reply_t           replies_due[$];
    int               errors;
    int               reply_index;

    function int count();
        return members.size();
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

    // apply one accepted word to the shadow set and queue its reply
    function void note_request(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key);
        int     slot;
        bit     hit;
        reply_t r;
        slot = 0;
        r = '0;
        while (slot < members.size() && $signed(members[slot]) < $signed(key))
            slot++;
        hit = (slot < members.size()) && (members[slot] == key);
        case (op)
            FUNC_ADD: begin
                if (!hit) begin
                    if (members.size() >= CAPACITY) begin
                        r.store_full = 1'b1;
                    end else begin
                        members.insert(slot, key);
                        r.success = 1'b1;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (hit) begin
                    members.delete(slot);
                    r.success = 1'b1;
                end
            end
            FUNC_CONTAINS: r.success = hit;
            default: ;
        endcase
        replies_due.push_back(r);
    endfunction

    function void flag_error(string msg);
        if (errors < 10)
            $display("[%0t] %s", $realtime, msg);
        errors++;
    endfunction

    function void check_response(logic [7:0] data);
        reply_t want;
        reply_t got;
        got = data[1:0];
        if (replies_due.size() == 0) begin
            flag_error($sformatf("unexpected result word %02h", data));
        end else begin
            want = replies_due.pop_front();
            if (got.success !== want.success || got.store_full !== want.store_full)
                flag_error($sformatf(
                    "result %0d: expected success=%0b store_full=%0b, got %0b %0b",
                    reply_index, want.success, want.store_full,
                    got.success, got.store_full));
        end
        reply_index++;
    endfunction
endclass

module tb_sorted_integer_set;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RUN_LIMIT   = 1_200_000;
    localparam int DRAIN_WAIT  = CAPACITY + 8;
    localparam int LONG_HOLD   = 3000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // func[1:0], key[33:2], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // success[0], store_full[1], zero fill

    set_tracker       tracker = new();
    int               cycle_count  = 0;
    int               replies_seen = 0;
    int               send_quiet   = 0;
    int               recv_quiet   = 0;
    logic [KEY_W-1:0] key_pool[48];

    sorted_integer_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and now and then a stretch of none
    function automatic int pick_gap(ref int quiet_left);
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if (r < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // result side: random stalls plus one long hold-off to back up the input
    always @(posedge aclk) begin : recv_ctrl
        int hold_left;
        int run_left;
        bit long_done;
        if (!aresetn) begin
            hold_left = 0;
            run_left  = 0;
            long_done = 0;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_done && replies_seen >= 150) begin
            long_done = 1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            m_tready <= 1'b1;
        end else begin
            hold_left = pick_gap(recv_quiet);
            run_left  = $urandom_range(1, 16);
            m_tready <= (hold_left == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_response(m_tdata);
            replies_seen <= replies_seen + 1;
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, key, op};
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(op, key);
    endtask

    function automatic logic [KEY_W-1:0] stored_key();
        if (tracker.count() == 0)
            return key_pool[$urandom_range(0, 47)];
        return tracker.members[$urandom_range(0, tracker.count() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return key_pool[$urandom_range(0, 47)];
        if (r < 80)
            return stored_key();
        return $urandom();
    endfunction

    // roughly add / remove / contains / unused in the given percentages
    task automatic send_mixed(input int p_add, input int p_rem, input int p_has);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_add)
            send_op(FUNC_ADD, any_key());
        else if (r < p_add + p_rem)
            send_op(FUNC_REMOVE, ($urandom_range(0, 2) != 0) ? stored_key() : any_key());
        else if (r < p_add + p_rem + p_has)
            send_op(FUNC_CONTAINS, any_key());
        else
            send_op(FUNC_UNUSED, any_key());
    endtask

    initial begin
        for (int i = 0; i < 48; i++)
            key_pool[i] = (i < 16) ? KEY_W'(i - 8) : $urandom();
        key_pool[16] = 32'h8000_0000;
        key_pool[17] = 32'h7FFF_FFFF;
        key_pool[18] = 32'h8000_0001;
        key_pool[19] = 32'h7FFF_FFFE;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, extremes, duplicates, unused code, ends and middle
        send_op(FUNC_CONTAINS, 32'd5);
        send_op(FUNC_REMOVE,   32'd5);
        send_op(FUNC_ADD,      32'h8000_0000);
        send_op(FUNC_ADD,      32'h7FFF_FFFF);
        send_op(FUNC_ADD,      32'd0);
        send_op(FUNC_ADD,      32'hFFFF_FFFF);
        send_op(FUNC_ADD,      32'd1);
        send_op(FUNC_ADD,      32'h8000_0001);
        send_op(FUNC_ADD,      32'h7FFF_FFFE);
        send_op(FUNC_ADD,      32'd0);
        send_op(FUNC_CONTAINS, 32'h8000_0000);
        send_op(FUNC_CONTAINS, 32'h7FFF_FFFF);
        send_op(FUNC_CONTAINS, 32'd2);
        send_op(FUNC_UNUSED,   32'd0);
        send_op(FUNC_UNUSED,   32'hFFFF_FFFF);
        send_op(FUNC_REMOVE,   32'h7FFF_FFFF);
        send_op(FUNC_REMOVE,   32'h8000_0000);
        send_op(FUNC_REMOVE,   32'd0);
        send_op(FUNC_REMOVE,   32'd0);
        send_op(FUNC_CONTAINS, 32'd0);
        send_op(FUNC_ADD,      32'h7FFF_FFFF);

        // churn on a small key pool so hits are common
        repeat (160) send_mixed(40, 25, 30);

        // fill to capacity with fresh keys
        while (tracker.count() < CAPACITY) begin
            if ($urandom_range(0, 99) < 88)
                send_op(FUNC_ADD, $urandom());
            else
                send_op(FUNC_CONTAINS, stored_key());
        end

        // full store: refused adds, duplicate adds, lookups, a few removes
        repeat (40) begin
            case ($urandom_range(0, 5))
                0, 1: send_op(FUNC_ADD, $urandom());
                2:    send_op(FUNC_ADD, stored_key());
                3:    send_op(FUNC_CONTAINS, any_key());
                4:    send_op(FUNC_REMOVE, stored_key());
                default: send_op(FUNC_UNUSED, $urandom());
            endcase
        end

        // drain, mostly removes of stored keys
        repeat (260) send_mixed(10, 70, 15);
        while (tracker.count() > 0)
            send_op(FUNC_REMOVE, stored_key());
        send_op(FUNC_CONTAINS, 32'h7FFF_FFFF);

        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
